/* src/toroidal_life_grid_engine_macros.svh */
// assertion macros used by the checker file tlge_checker.sv
`ifndef TOROIDAL_LIFE_GRID_ENGINE_MACROS_SVH
`define TOROIDAL_LIFE_GRID_ENGINE_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define TLGE_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tlge check failed");

// consequent checked in the cycle after the antecedent
`define TLGE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tlge check failed");

`endif

/* src/tlge_pkg.sv */
`timescale 1ns / 1ps

package tlge_pkg;

    localparam int OP_W       = 2;
    localparam int COORD_W    = 6;
    localparam int SIZE_W     = 7;
    localparam int ROW_CNT_W  = 8;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 8;

    localparam int MIN_SIZE    = 3;
    localparam int RESET_SIZE  = 64;
    localparam int BIRTH_COUNT = 3;
    localparam int STAY_COUNT  = 2;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE   = 2'd0,
        OP_READ    = 2'd1,
        OP_TOGGLE  = 2'd2,
        OP_ADVANCE = 2'd3
    } op_t;

    typedef enum logic {
        CFG_COLS = 1'b0,
        CFG_ROWS = 1'b1
    } cfg_idx_t;

    typedef logic [SIZE_W-1:0]    dim_t;
    typedef logic [ROW_CNT_W-1:0] row_cnt_t;

    // clamp a size register to [3, max_val]
    function automatic dim_t eff_size(input dim_t val, input int unsigned max_val);
        dim_t res;
        if (val < dim_t'(MIN_SIZE))
            res = dim_t'(MIN_SIZE);
        else if (32'(val) > max_val)
            res = dim_t'(max_val);
        else
            res = val;
        return res;
    endfunction

endpackage

/* src/toroidal_life_grid_engine.sv */
`timescale 1ns / 1ps

// channel  | dir | tdata fields, lowest bit up                       | beat
// ---------+-----+---------------------------------------------------+-------------------
// s        | in  | op[1:0], col[7:2], row[13:8], alive_in[14], 0[15] | one command
// m        | out | cell_alive[0], completed_op[2:1], zeros[7:3]      | one result
// cfg      | in  | cfg_addr 0 cols_in_use, 1 rows_in_use             | one register write
//
// write, read and toggle: accept with row read, modify and write back, result
// in an advance one row word of the grid memory is read and one written per cycle, and
// a three-row window feeds a full row of rule logic
// after reset a clearing pass writes MAX_ROWS rows of bank zero; s_tready stays low meanwhile
// a finished result waits in the output register while the next beat is accepted; the engine
// only holds in its final state when a previous result has not been taken yet

module toroidal_life_grid_engine #(
    parameter int MAX_COLS = 64,
    parameter int MAX_ROWS = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // op, col, row, alive_in, zero pad
    input  logic [tlge_pkg::IN_DATA_W-1:0]      s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // cell_alive, completed_op, zero pad
    output logic [tlge_pkg::OUT_DATA_W-1:0]     m_tdata,
    input  logic                                cfg_wr_en,
    input  tlge_pkg::cfg_idx_t                  cfg_addr,
    input  logic [tlge_pkg::SIZE_W-1:0]         cfg_wr_data
);
    import tlge_pkg::*;

    localparam int RW    = $clog2(MAX_ROWS);
    localparam int CW    = $clog2(MAX_COLS);
    localparam int DEPTH = 2 * MAX_ROWS;
    localparam int AW    = $clog2(DEPTH);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CELL,
        ST_ADV,
        ST_ADV_ZERO,
        ST_DONE
    } state_t;

    function automatic logic [AW-1:0] row_addr(input logic bank, input logic [RW-1:0] row);
        return AW'(row) + (bank ? AW'(MAX_ROWS) : AW'(0));
    endfunction

    state_t              state_reg;
    dim_t                cols_reg;
    dim_t                rows_reg;
    dim_t                nc;
    dim_t                nr;
    logic                bank_reg;

    // grid memory: bank 0 rows then bank 1 rows, one word per row
    logic [MAX_COLS-1:0] mem [DEPTH];
    logic [MAX_COLS-1:0] rdata_reg;
    logic                mem_rd_en;
    logic                mem_wr_en;
    logic [AW-1:0]       mem_rd_addr;
    logic [AW-1:0]       mem_wr_addr;
    logic [MAX_COLS-1:0] mem_wr_data;

    // input beat fields
    op_t                 in_op;
    logic [COORD_W-1:0]  in_col;
    logic [COORD_W-1:0]  in_row;
    logic                in_alive;
    logic                in_fire;
    logic                in_range;

    // latched command
    op_t                 op_reg;
    logic [CW-1:0]       col_reg;
    logic [RW-1:0]       row_reg;
    logic                alive_reg;
    logic                range_reg;
    logic                res_alive_reg;
    logic [MAX_COLS-1:0] cell_word;

    // generation sweep
    row_cnt_t            rd_cnt_reg;
    logic                rvalid_reg;
    logic [1:0]          fill_reg;
    logic                win_ready_reg;
    logic [MAX_COLS-1:0] win_up_reg;
    logic [MAX_COLS-1:0] win_mid_reg;
    logic [MAX_COLS-1:0] win_dn_reg;
    logic [RW-1:0]       wr_row_reg;
    logic [RW-1:0]       clr_row_reg;
    logic                adv_rd_en;
    logic [RW-1:0]       adv_rd_row;
    logic [MAX_COLS-1:0] rule_row;

    // output register
    logic                m_valid_reg;
    logic                m_alive_reg;
    op_t                 m_op_reg;

    assign nc = eff_size(cols_reg, MAX_COLS);
    assign nr = eff_size(rows_reg, MAX_ROWS);

    assign in_op    = op_t'(s_tdata[1:0]);
    assign in_col   = s_tdata[7:2];
    assign in_row   = s_tdata[13:8];
    assign in_alive = s_tdata[14];
    assign in_fire  = s_tvalid && s_tready;
    assign in_range = (dim_t'(in_col) < nc) && (dim_t'(in_row) < nr);

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(OUT_DATA_W - 3){1'b0}}, m_op_reg, m_alive_reg};

    // read order for a sweep: last active row, rows 0 .. nr-1, then row 0 again
    assign adv_rd_en = (state_reg == ST_ADV) && (rd_cnt_reg < row_cnt_t'(nr) + row_cnt_t'(2));

    always_comb
    begin
        if (rd_cnt_reg == '0)
            adv_rd_row = RW'(nr - dim_t'(1));
        else if (rd_cnt_reg == row_cnt_t'(nr) + row_cnt_t'(1))
            adv_rd_row = '0;
        else
            adv_rd_row = RW'(rd_cnt_reg - row_cnt_t'(1));
    end

    // modified row word for a cell command
    always_comb
    begin
        cell_word = rdata_reg;
        case (op_reg)
            OP_WRITE:  cell_word[col_reg] = alive_reg;
            OP_TOGGLE: cell_word[col_reg] = ~rdata_reg[col_reg];
            default:   ;
        endcase
    end

    tlge_row_rule #(
        .COLS (MAX_COLS)
    ) u_row_rule (
        .row_up   (win_up_reg),
        .row_mid  (win_mid_reg),
        .row_dn   (win_dn_reg),
        .cols_eff (nc),
        .row_out  (rule_row)
    );

    // memory port steering, one owner per state
    always_comb
    begin
        mem_rd_en   = 1'b0;
        mem_rd_addr = row_addr(bank_reg, RW'(in_row));
        mem_wr_en   = 1'b0;
        mem_wr_addr = row_addr(1'b0, clr_row_reg);
        mem_wr_data = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                mem_wr_en = 1'b1;
            end
            ST_IDLE:
            begin
                mem_rd_en = in_fire && (in_op != OP_ADVANCE) && in_range;
            end
            ST_CELL:
            begin
                mem_wr_en   = range_reg && (op_reg != OP_READ);
                mem_wr_addr = row_addr(bank_reg, row_reg);
                mem_wr_data = cell_word;
            end
            ST_ADV:
            begin
                mem_rd_en   = adv_rd_en;
                mem_rd_addr = row_addr(bank_reg, adv_rd_row);
                mem_wr_en   = win_ready_reg;
                mem_wr_addr = row_addr(~bank_reg, wr_row_reg);
                mem_wr_data = rule_row;
            end
            ST_ADV_ZERO:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = row_addr(~bank_reg, wr_row_reg);
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_wr_en)
            mem[mem_wr_addr] <= mem_wr_data;
        if (mem_rd_en)
            rdata_reg <= mem[mem_rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            cols_reg      <= dim_t'(RESET_SIZE);
            rows_reg      <= dim_t'(RESET_SIZE);
            bank_reg      <= 1'b0;
            clr_row_reg   <= '0;
            rd_cnt_reg    <= '0;
            rvalid_reg    <= 1'b0;
            fill_reg      <= '0;
            win_ready_reg <= 1'b0;
            wr_row_reg    <= '0;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_addr)
                    CFG_COLS: cols_reg <= cfg_wr_data;
                    CFG_ROWS: rows_reg <= cfg_wr_data;
                    default:  ;
                endcase
            end

            // the final state reloads the output register itself
            if (m_valid_reg && m_tready && (state_reg != ST_DONE))
                m_valid_reg <= 1'b0;

            case (state_reg)
                ST_CLEAR:
                begin
                    clr_row_reg <= clr_row_reg + RW'(1);
                    if (clr_row_reg == RW'(MAX_ROWS - 1))
                        state_reg <= ST_IDLE;
                end
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        op_reg        <= in_op;
                        col_reg       <= CW'(in_col);
                        row_reg       <= RW'(in_row);
                        alive_reg     <= in_alive;
                        range_reg     <= in_range;
                        res_alive_reg <= 1'b0;
                        rd_cnt_reg    <= '0;
                        rvalid_reg    <= 1'b0;
                        fill_reg      <= '0;
                        win_ready_reg <= 1'b0;
                        wr_row_reg    <= '0;
                        state_reg     <= (in_op == OP_ADVANCE) ? ST_ADV : ST_CELL;
                    end
                end
                ST_CELL:
                begin
                    res_alive_reg <= range_reg & cell_word[col_reg];
                    state_reg     <= ST_DONE;
                end
                ST_ADV:
                begin
                    if (adv_rd_en)
                        rd_cnt_reg <= rd_cnt_reg + row_cnt_t'(1);
                    rvalid_reg <= adv_rd_en;

                    // shift the three-row window as row words come back
                    if (rvalid_reg)
                    begin
                        win_up_reg    <= win_mid_reg;
                        win_mid_reg   <= win_dn_reg;
                        win_dn_reg    <= rdata_reg;
                        win_ready_reg <= (fill_reg >= 2'd2);
                        if (fill_reg != 2'd3)
                            fill_reg <= fill_reg + 2'd1;
                    end
                    else
                    begin
                        win_ready_reg <= 1'b0;
                    end

                    if (win_ready_reg)
                    begin
                        wr_row_reg <= wr_row_reg + RW'(1);
                        if (wr_row_reg == RW'(nr - dim_t'(1)))
                        begin
                            if (32'(nr) == MAX_ROWS)
                            begin
                                bank_reg  <= ~bank_reg;
                                state_reg <= ST_DONE;
                            end
                            else
                            begin
                                state_reg <= ST_ADV_ZERO;
                            end
                        end
                    end
                end
                ST_ADV_ZERO:
                begin
                    // rows past the active area are written dead
                    wr_row_reg <= wr_row_reg + RW'(1);
                    if (wr_row_reg == RW'(MAX_ROWS - 1))
                    begin
                        bank_reg  <= ~bank_reg;
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    if (!m_valid_reg || m_tready)
                    begin
                        m_valid_reg <= 1'b1;
                        m_alive_reg <= res_alive_reg;
                        m_op_reg    <= op_reg;
                        state_reg   <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

/* src/tlge_row_rule.sv */
`timescale 1ns / 1ps

module tlge_row_rule #(
    parameter int COLS = 64
) (
    input  logic [COLS-1:0] row_up,
    input  logic [COLS-1:0] row_mid,
    input  logic [COLS-1:0] row_dn,
    input  tlge_pkg::dim_t  cols_eff,
    output logic [COLS-1:0] row_out
);
    import tlge_pkg::*;

    localparam int CW = $clog2(COLS);

    logic [CW-1:0] last_idx;

    assign last_idx = CW'(cols_eff - dim_t'(1));

    for (genvar c = 0; c < COLS; c++)
    begin : g_col
        logic       l_up, l_mid, l_dn;
        logic       r_up, r_mid, r_dn;
        logic       active;
        logic [3:0] count;

        assign active  = (32'(cols_eff) > c);

        // left neighbor wraps to the last active column
        if (c == 0)
        begin : g_left_wrap
            assign l_up  = row_up[last_idx];
            assign l_mid = row_mid[last_idx];
            assign l_dn  = row_dn[last_idx];
        end
        else
        begin : g_left
            assign l_up  = row_up[c-1];
            assign l_mid = row_mid[c-1];
            assign l_dn  = row_dn[c-1];
        end

        // right neighbor wraps to column zero past the last active column
        if (c == COLS - 1)
        begin : g_right_wrap
            assign r_up  = row_up[0];
            assign r_mid = row_mid[0];
            assign r_dn  = row_dn[0];
        end
        else
        begin : g_right
            logic is_last;

            assign is_last = (32'(cols_eff) == c + 1);
            assign r_up  = is_last ? row_up[0]  : row_up[c+1];
            assign r_mid = is_last ? row_mid[0] : row_mid[c+1];
            assign r_dn  = is_last ? row_dn[0]  : row_dn[c+1];
        end

        assign count = 4'(l_up) + 4'(row_up[c]) + 4'(r_up)
                     + 4'(l_mid) + 4'(r_mid)
                     + 4'(l_dn) + 4'(row_dn[c]) + 4'(r_dn);

        assign row_out[c] = active & ((count == 4'(BIRTH_COUNT))
                          | (row_mid[c] & (count == 4'(STAY_COUNT))));
    end

endmodule

/* src/tlge_checker.sv */
`timescale 1ns / 1ps
`include "toroidal_life_grid_engine_macros.svh"

module tlge_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [tlge_pkg::OUT_DATA_W-1:0] m_tdata
);
    import tlge_pkg::*;

    logic s_beat;
    logic m_stall;
    logic adv_result;

    assign s_beat     = s_tvalid && s_tready;
    assign m_stall    = m_tvalid && !m_tready;
    assign adv_result = m_tvalid && (m_tdata[2:1] == OP_ADVANCE);

    // a stalled result holds
    `TLGE_ASSERT_NEXT(a_result_holds, clk, rst_n, m_stall, m_tvalid && $stable(m_tdata))

    // one command at a time: busy right after a beat is taken
    `TLGE_ASSERT_NEXT(a_busy_after_beat, clk, rst_n, s_beat, !s_tready)

    // a generation step reports a dead cell
    `TLGE_ASSERT_SAME(a_advance_zero, clk, rst_n, adv_result, !m_tdata[0])

    // pad bits of a result stay zero
    `TLGE_ASSERT_SAME(a_result_pad, clk, rst_n, m_tvalid, m_tdata[7:3] == 5'd0)

endmodule

bind toroidal_life_grid_engine tlge_checker u_tlge_checker (.*);

/* verif/life_grid_checker.sv */
`timescale 1ns / 1ps

module life_grid_checker #(
    parameter int MAX_COLS = 64,
    parameter int MAX_ROWS = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    // op, col, row, alive_in, zero pad
    input  logic [tlge_pkg::IN_DATA_W-1:0]   s_tdata,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    // cell_alive, completed_op, zero pad
    input  logic [tlge_pkg::OUT_DATA_W-1:0]  m_tdata,
    input  logic                             cfg_wr_en,
    input  tlge_pkg::cfg_idx_t               cfg_addr,
    input  logic [tlge_pkg::SIZE_W-1:0]      cfg_wr_data,
    output int                               pending_results,
    output int                               mismatch_count
);
    import tlge_pkg::*;

    typedef struct packed {
        logic alive;
        op_t  op;
    } cell_result_t;

    logic [MAX_COLS-1:0] live_cells [MAX_ROWS];
    dim_t                cols_reg;
    dim_t                rows_reg;
    cell_result_t        expected_results [$];
    int                  errors;

    assign mismatch_count = errors;

    function automatic int fit_dim(input dim_t v, input int max_val);
        int n;
        n = int'(v);
        if (n < MIN_SIZE)
            n = MIN_SIZE;
        else if (n > max_val)
            n = max_val;
        return n;
    endfunction

    // one generation of b3/s23 on the active torus, inactive cells end up dead
    task automatic step_generation();
        logic [MAX_COLS-1:0] next_cells [MAX_ROWS];
        int nc;
        int nr;
        int neighbors;
        nc = fit_dim(cols_reg, MAX_COLS);
        nr = fit_dim(rows_reg, MAX_ROWS);
        for (int r = 0; r < MAX_ROWS; r++)
        begin
            for (int c = 0; c < MAX_COLS; c++)
            begin
                next_cells[r][c] = 1'b0;
                if (r < nr && c < nc)
                begin
                    neighbors = 0;
                    for (int dr = -1; dr <= 1; dr++)
                    begin
                        for (int dc = -1; dc <= 1; dc++)
                        begin
                            if (dr != 0 || dc != 0)
                                neighbors += live_cells[(r + nr + dr) % nr][(c + nc + dc) % nc];
                        end
                    end
                    if (live_cells[r][c])
                        next_cells[r][c] = (neighbors == STAY_COUNT || neighbors == BIRTH_COUNT);
                    else
                        next_cells[r][c] = (neighbors == BIRTH_COUNT);
                end
            end
        end
        live_cells = next_cells;
    endtask

    task automatic apply_command(input logic [IN_DATA_W-1:0] beat, output cell_result_t res);
        op_t  op;
        int   col;
        int   row;
        logic alive_in;
        op       = op_t'(beat[1:0]);
        col      = int'(beat[7:2]);
        row      = int'(beat[13:8]);
        alive_in = beat[14];
        res.op    = op;
        res.alive = 1'b0;
        if (op == OP_ADVANCE)
            step_generation();
        else if (col < fit_dim(cols_reg, MAX_COLS) && row < fit_dim(rows_reg, MAX_ROWS))
        begin
            if (op == OP_WRITE)
                live_cells[row][col] = alive_in;
            else if (op == OP_TOGGLE)
                live_cells[row][col] = ~live_cells[row][col];
            res.alive = live_cells[row][col];
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        cell_result_t got;
        cell_result_t want;
        cell_result_t fresh;
        if (!rst_n)
        begin
            for (int r = 0; r < MAX_ROWS; r++)
                live_cells[r] = '0;
            cols_reg = dim_t'(RESET_SIZE);
            rows_reg = dim_t'(RESET_SIZE);
            expected_results.delete();
            errors = 0;
            pending_results <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.alive = m_tdata[0];
                got.op    = op_t'(m_tdata[2:1]);
                if (expected_results.size() == 0)
                begin
                    $error("result beat with nothing pending: cell_alive %0d completed_op %0d",
                           got.alive, got.op);
                    errors++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.alive !== want.alive)
                    begin
                        $error("cell_alive: expected %0d, actual %0d", want.alive, got.alive);
                        errors++;
                    end
                    if (got.op !== want.op)
                    begin
                        $error("completed_op: expected %0d, actual %0d", want.op, got.op);
                        errors++;
                    end
                end
            end
            if (cfg_wr_en)
            begin
                if (cfg_addr == CFG_COLS)
                    cols_reg = cfg_wr_data;
                else
                    rows_reg = cfg_wr_data;
            end
            if (s_tvalid && s_tready)
            begin
                apply_command(s_tdata, fresh);
                expected_results.push_back(fresh);
            end
            pending_results <= expected_results.size();
        end
    end

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps

module tb;
    import tlge_pkg::*;

    localparam int MAX_COLS     = 64;
    localparam int MAX_ROWS     = 64;
    // an advance sweeps all MAX_ROWS rows, give it some slack
    localparam int SETTLE       = MAX_ROWS + 16;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 96;
    localparam int PHASES       = 6;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    // op[1:0], col[7:2], row[13:8], alive_in[14], zero[15]
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    // cell_alive[0], completed_op[2:1], zeros[7:3]
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_wr_en;
    cfg_idx_t              cfg_addr;
    dim_t                  cfg_wr_data;

    int tx_idle_pct;
    int rx_stall_pct;
    int cycles;
    int items_sent;
    int cols_eff;
    int rows_eff;
    int pending_results;
    int mismatch_count;

    // size settings per random phase, register extremes and out-of-range values included
    int phase_cols [PHASES] = '{64, 3, 0, 127, 5, 16};
    int phase_rows [PHASES] = '{64, 3, 127, 2, 7, 12};

    toroidal_life_grid_engine #(
        .MAX_COLS(MAX_COLS),
        .MAX_ROWS(MAX_ROWS)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_addr   (cfg_addr),
        .cfg_wr_data(cfg_wr_data)
    );

    // watches all three channels, predicts every result beat and compares
    life_grid_checker #(
        .MAX_COLS(MAX_COLS),
        .MAX_ROWS(MAX_ROWS)
    ) u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_addr       (cfg_addr),
        .cfg_wr_data    (cfg_wr_data),
        .pending_results(pending_results),
        .mismatch_count (mismatch_count)
    );

    always #5 clk = ~clk;

    // result side backpressure, rate set per phase
    always @(posedge clk)
        m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic int fit_size(input int v, input int max_val);
        if (v < MIN_SIZE)
            return MIN_SIZE;
        if (v > max_val)
            return max_val;
        return v;
    endfunction

    // mostly inside the active area, now and then anywhere the field allows
    function automatic int pick_coord(input int size);
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(0, size - 1);
        return $urandom_range(0, 63);
    endfunction

    // one command beat; valid stays high between back-to-back beats
    task automatic send_cmd(input op_t op, input int col, input int row, input logic alive);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, alive, row[5:0], col[5:0], op};
        do
            @(posedge clk);
        while (!s_tready);
        items_sent++;
    endtask

    // hold off the sender until every result is back and the engine is quiet
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // both size registers on consecutive cycles, enable held high across them
    task automatic set_sizes(input int cols, input int rows);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= CFG_COLS;
        cfg_wr_data <= dim_t'(cols);
        @(posedge clk);
        cfg_addr    <= CFG_ROWS;
        cfg_wr_data <= dim_t'(rows);
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        cols_eff = fit_size(cols, MAX_COLS);
        rows_eff = fit_size(rows, MAX_ROWS);
    endtask

    task automatic random_command();
        int   pick;
        op_t  op;
        pick = $urandom_range(0, 99);
        if (pick < 35)
            op = OP_WRITE;
        else if (pick < 60)
            op = OP_READ;
        else if (pick < 80)
            op = OP_TOGGLE;
        else
            op = OP_ADVANCE;
        send_cmd(op, pick_coord(cols_eff), pick_coord(rows_eff), 1'($urandom_range(0, 1)));
    endtask

    // glider dropped at a random spot (wrapped), run a few generations, then probe around it
    task automatic glider_burst();
        int base_c;
        int base_r;
        int gens;
        int glider_r [5] = '{0, 1, 2, 2, 2};
        int glider_c [5] = '{1, 2, 0, 1, 2};
        base_c = $urandom_range(0, cols_eff - 1);
        base_r = $urandom_range(0, rows_eff - 1);
        gens   = $urandom_range(1, 4);
        for (int i = 0; i < 5; i++)
            send_cmd(OP_WRITE, (base_c + glider_c[i]) % cols_eff,
                     (base_r + glider_r[i]) % rows_eff, 1'b1);
        repeat (gens) send_cmd(OP_ADVANCE, $urandom_range(0, 63), $urandom_range(0, 63), 1'b0);
        repeat (2)
            send_cmd(OP_READ, (base_c + $urandom_range(0, 3)) % cols_eff,
                     (base_r + $urandom_range(0, 3)) % rows_eff, 1'b0);
    endtask

    initial
    begin
        int phase_start;
        clk          = 1'b0;
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        m_tready     = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_addr     = CFG_COLS;
        cfg_wr_data  = '0;
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        cycles       = 0;
        items_sent   = 0;
        cols_eff     = RESET_SIZE;
        rows_eff     = RESET_SIZE;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        // the clearing pass after reset keeps the engine busy for a while
        repeat (SETTLE) @(posedge clk);

        // directed: blinker straddling the column wrap, reset size grid
        send_cmd(OP_READ,   0,  0, 1'b0);
        send_cmd(OP_WRITE, 63,  0, 1'b1);
        send_cmd(OP_WRITE,  0,  0, 1'b1);
        send_cmd(OP_WRITE,  1,  0, 1'b1);
        send_cmd(OP_ADVANCE, 0, 0, 1'b0);
        // now vertical, straddling the row wrap
        send_cmd(OP_READ,   0, 63, 1'b0);
        send_cmd(OP_READ,   0,  1, 1'b0);
        send_cmd(OP_READ,  63,  0, 1'b0);
        send_cmd(OP_TOGGLE, 0,  0, 1'b0);
        send_cmd(OP_TOGGLE, 0,  0, 1'b0);
        send_cmd(OP_WRITE, 63, 63, 1'b1);
        send_cmd(OP_WRITE,  0,  1, 1'b0);
        send_cmd(OP_ADVANCE, 63, 63, 1'b1);
        send_cmd(OP_READ,  63, 63, 1'b0);
        // block made of the four corner cells, only stable with corner wrap
        send_cmd(OP_WRITE,  0,  0, 1'b1);
        send_cmd(OP_WRITE, 63,  0, 1'b1);
        send_cmd(OP_WRITE,  0, 63, 1'b1);
        send_cmd(OP_WRITE, 63, 63, 1'b1);
        send_cmd(OP_ADVANCE, 0, 0, 1'b0);
        send_cmd(OP_READ,  63,  0, 1'b0);

        // sizes below the minimum act as 3x3, addresses past it are ignored
        drain();
        set_sizes(2, 0);
        send_cmd(OP_WRITE,  5,  1, 1'b1);
        send_cmd(OP_TOGGLE, 63, 63, 1'b0);
        send_cmd(OP_WRITE,  2,  2, 1'b1);
        send_cmd(OP_READ,   2,  2, 1'b0);
        send_cmd(OP_ADVANCE, 0, 0, 1'b0);
        send_cmd(OP_READ,   1,  1, 1'b0);

        // random phases: receiver-heavy stalling, then sender-heavy idling, then none
        for (int p = 0; p < PHASES; p++)
        begin
            drain();
            set_sizes(phase_cols[p], phase_rows[p]);
            case (p / 2)
                0: begin tx_idle_pct = 30; rx_stall_pct = 80; end
                1: begin tx_idle_pct = 80; rx_stall_pct = 30; end
                default: begin tx_idle_pct = 0; rx_stall_pct = 0; end
            endcase
            phase_start = items_sent;
            while (items_sent - phase_start < RANDOM_ITEMS / PHASES)
            begin
                if ($urandom_range(0, 99) < 15)
                    glider_burst();
                else
                    random_command();
            end
        end

        drain();
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
